[src/pnl_pkg.sv]
package pnl_pkg;

	// Field widths
	localparam int PRICE_BITS    = 24;
	localparam int QTY_BITS      = 20;
	localparam int POSITION_BITS = 25;
	localparam int FRAC_BITS     = 8;
	localparam int AVG_BITS      = 32;
	localparam int PNL_BITS      = 64;

	// Derived widths
	localparam int MAG_BITS   = POSITION_BITS - 1;        // magnitude of a legal position
	localparam int NEXT_BITS  = POSITION_BITS + 1;        // position plus a fill
	localparam int DIFF_BITS  = AVG_BITS + 1;             // signed price difference
	localparam int PROD_BITS  = POSITION_BITS + DIFF_BITS; // signed pnl product
	localparam int COSTA_BITS = AVG_BITS + MAG_BITS;      // avg * |old|
	localparam int COSTB_BITS = AVG_BITS + QTY_BITS;      // price * |fill|
	localparam int TOTAL_BITS = COSTA_BITS + 1;           // total cost
	localparam int DIV_STEPS  = AVG_BITS;
	localparam int CNT_BITS   = $clog2(DIV_STEPS);

	localparam logic [POSITION_BITS-1:0] POS_MAX = {1'b0, {MAG_BITS{1'b1}}};
	localparam logic [CNT_BITS-1:0]      CNT_LAST = CNT_BITS'(DIV_STEPS - 1);

	// Item commands and status codes
	localparam logic CMD_FILL  = 1'b0;
	localparam logic CMD_PRICE = 1'b1;
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef struct packed {
		logic                  cmd;
		logic                  side;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   qty;
	} pnl_in_t;

	typedef struct packed {
		logic signed [POSITION_BITS-1:0] net_position;
		logic [AVG_BITS-1:0]             average_price;
		logic signed [PNL_BITS-1:0]      realized_pnl;
		logic signed [PNL_BITS-1:0]      unrealized_pnl;
		logic                            status;
	} pnl_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_UPD
	} pnl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic mul;
		logic load;
		logic step;
		logic commit;
	} pnl_ctrl_t;

	// Datapath to controller
	typedef struct packed {
		logic div_needed;
		logic div_last;
		logic out_free;
	} pnl_stat_t;

endpackage

[src/pnl_ctrl.sv]
module pnl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	output pnl_pkg::pnl_ctrl_t ctrl,
	input  pnl_pkg::pnl_stat_t stat
);
	import pnl_pkg::*;

	pnl_state_t state_q, state_d;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence one item: capture, multiply, sum, divide when needed, commit
	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		item_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					ctrl.capture = 1'b1;
					state_d      = ST_MUL;
				end
			end
			ST_MUL: begin
				ctrl.mul = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				ctrl.load = 1'b1;
				state_d   = stat.div_needed ? ST_DIV : ST_UPD;
			end
			ST_DIV: begin
				ctrl.step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (stat.out_free) begin
					ctrl.commit = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[src/pnl_datapath.sv]
module pnl_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  pnl_pkg::pnl_in_t   item,
	input  pnl_pkg::pnl_ctrl_t ctrl,
	output pnl_pkg::pnl_stat_t stat,
	output logic               result_valid,
	input  logic               result_stall,
	output pnl_pkg::pnl_out_t  result
);
	import pnl_pkg::*;

	// Tracker state
	logic signed [POSITION_BITS-1:0] pos_q;
	logic [AVG_BITS-1:0]             avg_q;
	logic signed [PNL_BITS-1:0]      real_q;
	logic signed [PNL_BITS-1:0]      unreal_q;

	// Captured item
	logic                cmd_s1;
	logic                side_s1;
	logic [AVG_BITS-1:0] price_fx_s1;
	logic [QTY_BITS-1:0] qty_s1;

	// Multiply stage results
	logic signed [NEXT_BITS-1:0] next_s2;
	logic                        reject_s2;
	logic                        add_s2;
	logic [MAG_BITS-1:0]         size_s2;
	logic [COSTA_BITS-1:0]       cost_a_s2;
	logic [COSTB_BITS-1:0]       cost_b_s2;
	logic signed [PROD_BITS-1:0] prod_s2;

	// Divider
	logic [MAG_BITS-1:0] rem_q;
	logic [AVG_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0] cnt_q;

	logic out_valid_q;

	// Operand decode for the multiply stage
	logic [POSITION_BITS-1:0]    pos_neg;
	logic [MAG_BITS-1:0]         pos_mag;
	logic [MAG_BITS-1:0]         qty_mag;
	logic [NEXT_BITS-1:0]        fill_w;
	logic signed [NEXT_BITS-1:0] next_w;
	logic [NEXT_BITS-1:0]        next_neg;
	logic [POSITION_BITS-1:0]    next_mag;
	logic                        fill_pos;
	logic                        is_add;
	logic [MAG_BITS-1:0]         closed;
	logic signed [DIFF_BITS-1:0] pdiff;
	logic signed [DIFF_BITS-1:0] cdiff;
	logic signed [POSITION_BITS-1:0] mul_a;
	logic signed [DIFF_BITS-1:0]     mul_b;

	always_comb begin
		pos_neg  = -pos_q;
		pos_mag  = pos_q[POSITION_BITS-1] ? pos_neg[MAG_BITS-1:0] : pos_q[MAG_BITS-1:0];
		qty_mag  = MAG_BITS'(qty_s1);
		fill_w   = NEXT_BITS'(qty_s1);
		if (side_s1 == SIDE_SELL) begin
			fill_w = -fill_w;
		end
		next_w   = $signed({pos_q[POSITION_BITS-1], pos_q}) + $signed(fill_w);
		next_neg = -next_w;
		next_mag = next_w[NEXT_BITS-1] ? next_neg[POSITION_BITS-1:0]
		                               : next_w[POSITION_BITS-1:0];
		fill_pos = (side_s1 == SIDE_BUY) && (qty_s1 != '0);
		is_add   = (pos_q == '0)
		        || (!pos_q[POSITION_BITS-1] && fill_pos)
		        || (pos_q[POSITION_BITS-1] && (side_s1 == SIDE_SELL) && (qty_s1 != '0));
		closed   = (pos_mag < qty_mag) ? pos_mag : qty_mag;
		pdiff    = $signed({1'b0, price_fx_s1}) - $signed({1'b0, avg_q});
		cdiff    = fill_pos ? -pdiff : pdiff;
		// Share one signed multiplier between closing fills and price updates
		if (cmd_s1 == CMD_PRICE) begin
			mul_a = pos_q;
			mul_b = pdiff;
		end else begin
			mul_a = $signed({1'b0, closed});
			mul_b = cdiff;
		end
	end

	// Capture the item on transfer
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_s1      <= item.cmd;
			side_s1     <= item.side;
			price_fx_s1 <= AVG_BITS'(item.price) << FRAC_BITS;
			qty_s1      <= item.qty;
		end
	end

	// Register decode and products
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			next_s2   <= next_w;
			reject_s2 <= (cmd_s1 == CMD_FILL) && (next_mag > POS_MAX);
			add_s2    <= is_add;
			size_s2   <= next_mag[MAG_BITS-1:0];
			cost_a_s2 <= avg_q * pos_mag;
			cost_b_s2 <= price_fx_s1 * qty_s1;
			prod_s2   <= mul_a * mul_b;
		end
	end

	// Restoring divider: the quotient fits the average width, so the high
	// part of the total cost seeds the remainder
	logic [TOTAL_BITS-1:0] total;
	logic [MAG_BITS:0]     trial;
	logic                  fits;

	always_comb begin
		total = TOTAL_BITS'(cost_a_s2) + TOTAL_BITS'(cost_b_s2);
		trial = {rem_q, quo_q[AVG_BITS-1]};
		fits  = trial >= {1'b0, size_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= '0;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= total[COSTA_BITS-1:AVG_BITS];
			quo_q <= total[AVG_BITS-1:0];
		end else if (ctrl.step) begin
			rem_q <= fits ? MAG_BITS'(trial - {1'b0, size_s2}) : trial[MAG_BITS-1:0];
			quo_q <= {quo_q[AVG_BITS-2:0], fits};
		end
	end

	// Work out the state after this item
	logic signed [PNL_BITS:0]        real_sum;
	logic signed [PNL_BITS-1:0]      real_sat;
	logic signed [PNL_BITS-1:0]      prod_ext;
	logic signed [POSITION_BITS-1:0] pos_d;
	logic [AVG_BITS-1:0]             avg_d;
	logic signed [PNL_BITS-1:0]      real_d;
	logic signed [PNL_BITS-1:0]      unreal_d;
	logic                            status_d;
	logic                            flat;
	logic                            flip;

	always_comb begin
		prod_ext = {{(PNL_BITS-PROD_BITS){prod_s2[PROD_BITS-1]}}, prod_s2};
		real_sum = {real_q[PNL_BITS-1], real_q} + {prod_ext[PNL_BITS-1], prod_ext};
		if (real_sum[PNL_BITS] != real_sum[PNL_BITS-1]) begin
			real_sat = real_sum[PNL_BITS] ? {1'b1, {(PNL_BITS-1){1'b0}}}
			                              : {1'b0, {(PNL_BITS-1){1'b1}}};
		end else begin
			real_sat = real_sum[PNL_BITS-1:0];
		end
		flat     = (next_s2 == '0);
		flip     = next_s2[NEXT_BITS-1] != pos_q[POSITION_BITS-1];
		pos_d    = pos_q;
		avg_d    = avg_q;
		real_d   = real_q;
		unreal_d = unreal_q;
		status_d = STATUS_OK;
		if (cmd_s1 == CMD_PRICE) begin
			unreal_d = (pos_q == '0) ? '0 : prod_ext;
		end else if (reject_s2) begin
			status_d = STATUS_REJECT;
		end else begin
			pos_d = next_s2[POSITION_BITS-1:0];
			if (add_s2) begin
				avg_d = (size_s2 == '0) ? '0 : quo_q;
			end else begin
				real_d = real_sat;
				if (flat) begin
					avg_d = '0;
				end else if (flip) begin
					avg_d = price_fx_s1;
				end
			end
			if (flat) begin
				avg_d    = '0;
				unreal_d = '0;
			end
		end
	end

	// Commit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			avg_q    <= '0;
			real_q   <= '0;
			unreal_q <= '0;
		end else if (ctrl.commit) begin
			pos_q    <= pos_d;
			avg_q    <= avg_d;
			real_q   <= real_d;
			unreal_q <= unreal_d;
		end
	end

	// Output register: load on commit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			result.net_position   <= pos_d;
			result.average_price  <= avg_d;
			result.realized_pnl   <= real_d;
			result.unrealized_pnl <= unreal_d;
			result.status         <= status_d;
		end
	end

	assign result_valid    = out_valid_q;
	assign stat.out_free   = !out_valid_q || !result_stall;
	assign stat.div_last   = (cnt_q == CNT_LAST);
	assign stat.div_needed = (cmd_s1 == CMD_FILL) && !reject_s2 && add_s2 && (size_s2 != '0);

endmodule

[src/position_pnl_tracker.sv]
// Average-cost position and PnL tracker.
//
// Input channel (item_valid / item_stall / item): one transfer is a trade
// fill (cmd 0) or a market price update (cmd 1). Output channel
// (result_valid / result_stall / result): one result per item, giving the
// net position, average entry price, realized and unrealized PnL after it
// and a status bit that flags a fill rejected for position overflow.
//
// Price updates, reducing fills and rejected fills pass from capture
// through the multiply and sum steps to commit; fills that add to the
// position also pass through a restoring divider that gives the new
// average and retires one quotient bit per cycle. One item is in flight
// at a time, so a new item is not taken until the last one commits. The
// output register lets the next item be taken while a result still
// waits; if the receiver keeps stalling, the next item holds in its
// final step until the output register frees.
//
// Reset clears the position, average and PnL totals to zero and empties
// the output register; the block takes an item in the first cycle after.
module position_pnl_tracker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  pnl_pkg::pnl_in_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output pnl_pkg::pnl_out_t result
);
	import pnl_pkg::*;

	pnl_ctrl_t ctrl;
	pnl_stat_t stat;

	pnl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.ctrl       (ctrl),
		.stat       (stat)
	);

	pnl_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.ctrl         (ctrl),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
